### rtl/msrc_pkg.sv
// ----------------------------------------------------------------------------
// msrc_pkg
// shared types and constants of the modbus sensor reply checker
// ----------------------------------------------------------------------------
package msrc_pkg;

   // reply framing
   localparam int REPLY_BYTES = 19;
   localparam int WORDS       = 7;
   localparam int WORD_IDX_W  = $clog2(WORDS);

   typedef logic [4:0]  count_type;
   typedef logic [15:0] word_type;
   typedef word_type [WORDS-1:0] word_array_type;

   localparam count_type COUNT_FULL  = 5'(REPLY_BYTES);
   localparam count_type CRC_LO_AT   = 5'(REPLY_BYTES - 2);
   localparam count_type CRC_HI_AT   = 5'(REPLY_BYTES - 1);
   localparam count_type WORD_FIRST  = 5'd3;
   localparam count_type WORD_LAST   = 5'd16;
   localparam count_type WORD_OFFSET = 5'd4;

   // crc-16/modbus
   localparam word_type CRC_INIT = 16'hFFFF;
   localparam word_type CRC_POLY = 16'hA001;

   localparam logic [6:0] FAIL_LIMIT_RESET = 7'd60;

   // request codes
   localparam logic [1:0] FUNC_BYTE      = 2'd0;
   localparam logic [1:0] FUNC_END       = 2'd1;
   localparam logic [1:0] FUNC_SEND_FAIL = 2'd2;

   // result status codes
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_LENGTH     = 2'd1;
   localparam logic [1:0] STATUS_CRC        = 2'd2;
   localparam logic [1:0] STATUS_NOT_SENT   = 2'd3;

   // one processing step, issued by the top level
   typedef struct packed {
      logic byte_en;
      logic clear;
      logic end_en;
      logic fail_en;
   } op_type;

   // receiver view of the current reply
   typedef struct packed {
      logic full;
      logic crc_match;
   } rx_status_type;

endpackage

### rtl/msrc_crc_byte.sv
// ----------------------------------------------------------------------------
// msrc_crc_byte
// one byte of crc-16/modbus, eight shift steps unrolled
// ----------------------------------------------------------------------------
module msrc_crc_byte (
   input  msrc_pkg::word_type crc_cur,
   input  logic [7:0]         data_byte,
   output msrc_pkg::word_type crc_next
);

   always_comb begin
      msrc_pkg::word_type c;
      c = crc_cur ^ {8'h00, data_byte};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ msrc_pkg::CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      crc_next = c;
   end

endmodule

### rtl/msrc_receiver.sv
// ----------------------------------------------------------------------------
// msrc_receiver
// byte counter, running crc, received crc and capture of the seven readings
// ----------------------------------------------------------------------------
module msrc_receiver (
   input  logic                     clock,
   input  logic                     reset,
   input  msrc_pkg::op_type         op,
   input  logic [7:0]               rx_byte,
   output msrc_pkg::rx_status_type  rx_status,
   output msrc_pkg::word_array_type capture_words
);

   msrc_pkg::count_type       count_ff, count_in;
   msrc_pkg::word_type        crc_ff, crc_in;
   logic [7:0]                hold_ff, hold_in;
   msrc_pkg::word_type        crc_rx_ff, crc_rx_in;
   msrc_pkg::word_array_type  capture_ff;
   msrc_pkg::word_type        crc_next;
   msrc_pkg::count_type       cap_off;
   logic [msrc_pkg::WORD_IDX_W-1:0] cap_idx;
   logic                      cap_we;

   msrc_crc_byte u_crc (
      .crc_cur   (crc_ff),
      .data_byte (rx_byte),
      .crc_next  (crc_next)
   );

   // reading slot for an even byte position 4..16
   assign cap_off = count_ff - msrc_pkg::WORD_OFFSET;
   assign cap_idx = cap_off[msrc_pkg::WORD_IDX_W:1];

   always_comb begin
      count_in  = count_ff;
      crc_in    = crc_ff;
      hold_in   = hold_ff;
      crc_rx_in = crc_rx_ff;
      cap_we    = 1'b0;
      if (op.clear) begin
         count_in  = '0;
         crc_in    = msrc_pkg::CRC_INIT;
         hold_in   = '0;
         crc_rx_in = '0;
      end else if (op.byte_en && (count_ff < msrc_pkg::COUNT_FULL)) begin
         if (count_ff < msrc_pkg::CRC_LO_AT) begin
            crc_in = crc_next;
         end
         if ((count_ff >= msrc_pkg::WORD_FIRST) && (count_ff <= msrc_pkg::WORD_LAST)) begin
            if (count_ff[0]) begin
               hold_in = rx_byte;
            end else begin
               cap_we = 1'b1;
            end
         end else if (count_ff == msrc_pkg::CRC_LO_AT) begin
            crc_rx_in = {crc_rx_ff[15:8], rx_byte};
         end else if (count_ff == msrc_pkg::CRC_HI_AT) begin
            crc_rx_in = {rx_byte, crc_rx_ff[7:0]};
         end
         count_in = count_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         crc_ff    <= msrc_pkg::CRC_INIT;
         hold_ff   <= '0;
         crc_rx_ff <= '0;
      end else begin
         count_ff  <= count_in;
         crc_ff    <= crc_in;
         hold_ff   <= hold_in;
         crc_rx_ff <= crc_rx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cap_we) begin
         capture_ff[cap_idx] <= {hold_ff, rx_byte};
      end
   end

   assign rx_status.full      = (count_ff == msrc_pkg::COUNT_FULL);
   assign rx_status.crc_match = (crc_ff == crc_rx_ff);
   assign capture_words       = capture_ff;

endmodule

### rtl/msrc_evaluator.sv
// ----------------------------------------------------------------------------
// msrc_evaluator
// judges a reply, keeps committed readings, failure counter and availability,
// and holds the result word until it is taken
// ----------------------------------------------------------------------------
module msrc_evaluator (
   input  logic                     clock,
   input  logic                     reset,
   input  msrc_pkg::op_type         op,
   input  msrc_pkg::rx_status_type  rx_status,
   input  msrc_pkg::word_array_type capture_words,
   input  logic                     limit_we,
   input  logic [6:0]               limit_data,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output logic [1:0]               rsp_status,
   output msrc_pkg::word_array_type committed_words,
   output logic                     sensor_available,
   output logic [6:0]               failure_count
);

   logic                     valid_ff, valid_in;
   logic [1:0]               status_ff, status_in;
   msrc_pkg::word_array_type committed_ff, committed_in;
   logic                     avail_ff, avail_in;
   logic [6:0]               fail_ff, fail_in;
   logic [6:0]               limit_ff, limit_in;
   logic [6:0]               fail_inc;
   logic                     count_fail;

   assign fail_inc = fail_ff + 7'd1;

   always_comb begin
      status_in    = status_ff;
      committed_in = committed_ff;
      avail_in     = avail_ff;
      count_fail   = 1'b0;
      limit_in     = limit_we ? limit_data : limit_ff;
      valid_in     = valid_ff && !rsp_ready;
      if (op.fail_en) begin
         status_in  = msrc_pkg::STATUS_NOT_SENT;
         count_fail = 1'b1;
      end else if (op.end_en) begin
         if (!rx_status.full) begin
            status_in  = msrc_pkg::STATUS_LENGTH;
            count_fail = 1'b1;
         end else if (!rx_status.crc_match) begin
            status_in  = msrc_pkg::STATUS_CRC;
            count_fail = 1'b1;
         end else begin
            status_in    = msrc_pkg::STATUS_OK;
            committed_in = capture_words;
            avail_in     = 1'b1;
         end
      end
      if (op.fail_en || op.end_en) begin
         valid_in = 1'b1;
      end
      fail_in = fail_ff;
      if (count_fail) begin
         // limit reached: mark unavailable and restart the count
         if (fail_inc == limit_ff) begin
            fail_in  = '0;
            avail_in = 1'b0;
         end else begin
            fail_in = fail_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         committed_ff <= '0;
         avail_ff     <= 1'b1;
         fail_ff      <= '0;
         limit_ff     <= msrc_pkg::FAIL_LIMIT_RESET;
      end else begin
         valid_ff     <= valid_in;
         committed_ff <= committed_in;
         avail_ff     <= avail_in;
         fail_ff      <= fail_in;
         limit_ff     <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_status       = status_ff;
   assign committed_words  = committed_ff;
   assign sensor_available = avail_ff;
   assign failure_count    = fail_ff;

endmodule

### rtl/modbus_sensor_reply_checker.sv
// ----------------------------------------------------------------------------
// modbus_sensor_reply_checker
// checks 19-byte modbus rtu replies of a seven-reading soil sensor
// ----------------------------------------------------------------------------
// Takes one request word per clock: a reply byte, an end-of-reply marker or a
// send-failure marker. Bytes run through an unrolled crc-16/modbus update and
// the reading capture in the cycle after they are taken, so the block sustains
// one word per cycle; end-of-reply and send-failure words each give one result
// word via the input and output registers, other words give none. Results sit in an
// output register, so the input side keeps moving while a result waits and
// stalls only when a second result would have to overwrite an untaken one.
// Readings are committed only for a full reply with a matching crc; failures
// step a counter that clears availability when it reaches the limit written on
// the csr port (reset 60). Write the limit only while the block is idle.
// ----------------------------------------------------------------------------
module modbus_sensor_reply_checker (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_rx_byte,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_moisture_tenths,
   output logic [15:0] rsp_temperature_tenths,
   output logic [15:0] rsp_conductivity,
   output logic [15:0] rsp_ph_tenths,
   output logic [15:0] rsp_nitrogen_level,
   output logic [15:0] rsp_phosphorus_level,
   output logic [15:0] rsp_potassium_level,
   output logic        rsp_sensor_available,
   output logic [6:0]  rsp_failure_count,
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_failure_limit
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [1:0] in_func_ff, in_func_in;
   logic [7:0] in_byte_ff, in_byte_in;

   logic                     has_result;
   logic                     advance;
   msrc_pkg::op_type         op;
   msrc_pkg::rx_status_type  rx_status;
   msrc_pkg::word_array_type capture_words;
   msrc_pkg::word_array_type committed_words;

   // end and send-failure words produce a result and need the output slot
   assign has_result = (in_func_ff == msrc_pkg::FUNC_END) ||
                       (in_func_ff == msrc_pkg::FUNC_SEND_FAIL);
   assign advance    = in_valid_ff && (!has_result || !rsp_valid || rsp_ready);
   assign req_ready  = !in_valid_ff || advance;

   assign op.byte_en = advance && (in_func_ff == msrc_pkg::FUNC_BYTE);
   assign op.end_en  = advance && (in_func_ff == msrc_pkg::FUNC_END);
   assign op.fail_en = advance && (in_func_ff == msrc_pkg::FUNC_SEND_FAIL);
   assign op.clear   = op.end_en || op.fail_en;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_func_in  = in_func_ff;
      in_byte_in  = in_byte_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
         in_func_in  = req_func;
         in_byte_in  = req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      in_func_ff <= in_func_in;
      in_byte_ff <= in_byte_in;
   end

   msrc_receiver u_receiver (
      .clock         (clock),
      .reset         (reset),
      .op            (op),
      .rx_byte       (in_byte_ff),
      .rx_status     (rx_status),
      .capture_words (capture_words)
   );

   // limit register accepts a write every cycle
   assign csr_ready = 1'b1;

   msrc_evaluator u_evaluator (
      .clock            (clock),
      .reset            (reset),
      .op               (op),
      .rx_status        (rx_status),
      .capture_words    (capture_words),
      .limit_we         (csr_valid),
      .limit_data       (csr_failure_limit),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .committed_words  (committed_words),
      .sensor_available (rsp_sensor_available),
      .failure_count    (rsp_failure_count)
   );

   // committed readings in reply order
   assign rsp_moisture_tenths    = committed_words[0];
   assign rsp_temperature_tenths = committed_words[1];
   assign rsp_conductivity       = committed_words[2];
   assign rsp_ph_tenths          = committed_words[3];
   assign rsp_nitrogen_level     = committed_words[4];
   assign rsp_phosphorus_level   = committed_words[5];
   assign rsp_potassium_level    = committed_words[6];

endmodule

### rtl/msrc_checker.sv
// ----------------------------------------------------------------------------
// msrc_checker
// port-level checks of the modbus sensor reply checker
// ----------------------------------------------------------------------------
module msrc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic        rsp_sensor_available,
   input logic [6:0]  rsp_failure_count
);

   // no result word right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a good reply always leaves the sensor available
   a_ok_available: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == msrc_pkg::STATUS_OK)) |-> rsp_sensor_available)
      else $error("good reply without availability");

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_failure_count)
          && $stable(rsp_sensor_available)))
      else $error("stalled result changed");

   // the block only holds back requests while a result waits
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      (!req_ready) |-> rsp_valid)
      else $error("request stalled with empty result slot");

endmodule

bind modbus_sensor_reply_checker msrc_checker u_msrc_checker (.*);
